>>> hw/rtl/d2q9_pkg.sv
// D2Q9 collision unit package: default widths, rate register reset,
// lattice direction vectors and the quadrature weights.
// No dependencies.
package d2q9_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int NDIR           = 9;
  localparam int RATE_W         = 15;
  localparam logic [RATE_W-1:0] RATE_RESET = 15'd30913;

  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  // weight by direction class: rest, axis, diagonal; rounded to nearest
  function automatic int weight(input int cls, input int frac);
    int one;
    one = 1 << frac;
    if (cls == 0) return (4 * one + 4) / 9;
    if (cls == 1) return (one + 4) / 9;
    return (one + 18) / 36;
  endfunction

endpackage

>>> hw/rtl/d2q9_div.sv
// Pipelined restoring divider for velocity: (num << F) / den, truncated,
// saturated, zero when den is not positive. One quotient bit per stage.
// Depends on d2q9_pkg.
module d2q9_div import d2q9_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH+2:0] num,
  input  logic signed [DATA_WIDTH+3:0] den,
  output logic signed [DATA_WIDTH-1:0] quo
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + FRAC_BITS + 4;

  logic [W+2:0]  num_mag;
  logic [NW-1:0] num_sh;
  logic [NW-1:0] den_top;

  logic [NW-1:0] rem [W];
  logic [NW-1:0] dv  [W];
  logic [W-2:0]  qb  [W];
  logic          neg [W];
  logic          zr  [W];
  logic          ovf [W];

  logic [W-1:0]  qfull;

  always_comb begin
    num_mag = num[W+2] ? (W+3)'(-num) : (W+3)'(num);
    num_sh  = NW'(num_mag) << FRAC_BITS;
    den_top = NW'(den[W+2:0]) << (W - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_sh;
      dv[0]  <= NW'(den[W+2:0]);
      qb[0]  <= '0;
      neg[0] <= num[W+2];
      zr[0]  <= (den <= 0);
      ovf[0] <= (num_sh >= den_top);
    end
  end

  for (genvar s = 0; s < W - 1; s++) begin : g_stage
    localparam int I = W - 2 - s;
    logic [NW-1:0] ds;
    logic          ge;
    logic [W-2:0]  qn;
    always_comb begin
      ds = dv[s] << I;
      ge = (rem[s] >= ds);
      qn = qb[s];
      qn[I] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]   <= ge ? rem[s] - ds : rem[s];
        qb[s+1]    <= qn;
        dv[s+1]    <= dv[s];
        neg[s+1]   <= neg[s];
        zr[s+1]    <= zr[s];
        ovf[s+1]   <= ovf[s];
      end
    end
  end

  assign qfull = {1'b0, qb[W-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[W-1]) begin
        quo <= '0;
      end else if (ovf[W-1]) begin
        quo <= neg[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        quo <= neg[W-1] ? $signed(-qfull) : $signed(qfull);
      end
    end
  end

endmodule

>>> hw/rtl/d2q9_lane.sv
// One direction of the collision: equilibrium and relaxation, 8 stages.
// Depends on d2q9_pkg.
module d2q9_lane import d2q9_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int CX = 0,
  parameter int CY = 0
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic signed [DATA_WIDTH-1:0]               f,
  input  logic signed [DATA_WIDTH-1:0]               rho,
  input  logic signed [DATA_WIDTH-1:0]               ux,
  input  logic signed [DATA_WIDTH-1:0]               uy,
  input  logic signed [2*DATA_WIDTH-FRAC_BITS+1:0]   u2,
  input  logic        [RATE_W-1:0]                   omega,
  output logic signed [DATA_WIDTH-1:0]               g
);

  localparam int W   = DATA_WIDTH;
  localparam int BW  = 2 * W + 24;
  localparam int CLS = (CX != 0 ? 1 : 0) + (CY != 0 ? 1 : 0);
  localparam logic signed [BW-1:0] WGT  = BW'(weight(CLS, FRAC_BITS));
  localparam logic signed [BW-1:0] MAXV = {{(BW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [BW-1:0] MINV = ~MAXV;
  localparam logic signed [BW-1:0] ONE  = BW'(1) << FRAC_BITS;
  localparam logic signed [BW-1:0] HALF = BW'(1) << (FRAC_BITS - 1);

  function automatic logic signed [W-1:0] sat(input logic signed [BW-1:0] x);
    if (x > MAXV) return MAXV[W-1:0];
    if (x < MINV) return MINV[W-1:0];
    return x[W-1:0];
  endfunction

  function automatic logic signed [BW-1:0] rsh(input logic signed [BW-1:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  logic signed [BW-1:0] cu_w;
  logic signed [W-1:0]  cu1, cu2r, p3;
  logic signed [BW-1:0] sq2, pr4, wp5, op7;
  logic signed [W:0]    d6;
  logic signed [W-1:0]  f1, f2, f3, f4, f5, f6, f7;
  logic signed [W-1:0]  rho1, rho2, rho3;

  always_comb begin
    cu_w = BW'(CX) * BW'(ux) + BW'(CY) * BW'(uy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cu1  <= sat(cu_w);
      f1   <= f;
      rho1 <= rho;
      sq2  <= BW'(cu1) * BW'(cu1);
      cu2r <= cu1;
      f2   <= f1;
      rho2 <= rho1;
      p3   <= sat(ONE + 3 * BW'(cu2r) + ((9 * rsh(sq2) + 1) >>> 1)
                  - ((3 * BW'(u2) + 1) >>> 1));
      f3   <= f2;
      rho3 <= rho2;
      pr4  <= BW'(rho3) * BW'(p3);
      f4   <= f3;
      wp5  <= WGT * BW'(sat(rsh(pr4)));
      f5   <= f4;
      d6   <= (W+1)'(sat(rsh(wp5))) - (W+1)'(f5);
      f6   <= f5;
      op7  <= BW'(d6) * BW'($signed({1'b0, omega}));
      f7   <= f6;
      g    <= sat(BW'(f7) + rsh(op7));
    end
  end

endmodule

>>> hw/rtl/d2q9_bgk_cell_collision_unit.sv
// D2Q9 BGK collision unit: top level with input stage, velocity dividers,
// nine direction lanes and the output register. Depends on d2q9_pkg,
// d2q9_div and d2q9_lane.
//
// Usage: one item is the nine distributions of a lattice cell, taken on
// in_valid with in_stall low. The result item (nine relaxed values,
// density, vel_x, vel_y) appears on out_valid and is taken when out_stall
// is low. Throughput is one item per cycle while out_stall does not hold
// the pipeline. From acceptance to out_valid an item passes one input
// stage, the divider (one quotient bit per stage), eight lane stages and
// the output register. The divider pipeline sets the depth. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the relaxation rate with its default;
// the user must write relax_rate through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module d2q9_bgk_cell_collision_unit import d2q9_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] f_rest,
  input  logic signed [DATA_WIDTH-1:0] f_east,
  input  logic signed [DATA_WIDTH-1:0] f_north,
  input  logic signed [DATA_WIDTH-1:0] f_west,
  input  logic signed [DATA_WIDTH-1:0] f_south,
  input  logic signed [DATA_WIDTH-1:0] f_northeast,
  input  logic signed [DATA_WIDTH-1:0] f_northwest,
  input  logic signed [DATA_WIDTH-1:0] f_southwest,
  input  logic signed [DATA_WIDTH-1:0] f_southeast,
  input  logic                         cfg_wr_en,
  input  logic [RATE_W-1:0]            cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] g_rest,
  output logic signed [DATA_WIDTH-1:0] g_east,
  output logic signed [DATA_WIDTH-1:0] g_north,
  output logic signed [DATA_WIDTH-1:0] g_west,
  output logic signed [DATA_WIDTH-1:0] g_south,
  output logic signed [DATA_WIDTH-1:0] g_northeast,
  output logic signed [DATA_WIDTH-1:0] g_northwest,
  output logic signed [DATA_WIDTH-1:0] g_southwest,
  output logic signed [DATA_WIDTH-1:0] g_southeast,
  output logic signed [DATA_WIDTH-1:0] density,
  output logic signed [DATA_WIDTH-1:0] vel_x,
  output logic signed [DATA_WIDTH-1:0] vel_y
);

  localparam int W   = DATA_WIDTH;
  localparam int U2W = 2 * W - FRAC_BITS + 2;
  localparam int DLY = W + 1;
  localparam int LL  = 8;
  localparam int VL  = 1 + DLY + LL;
  localparam logic signed [W+3:0] MAXS = {5'b0, {(W-1){1'b1}}};
  localparam logic signed [W+3:0] MINS = ~MAXS;
  localparam logic signed [2*W:0] HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

  logic                en;
  logic [RATE_W-1:0]   relax_rate;
  logic [VL-1:0]       vld;

  logic signed [W-1:0] fin [NDIR];
  logic signed [W-1:0] f0  [NDIR];
  logic signed [W+3:0] sum0;
  logic signed [W+2:0] mx0, my0;

  logic signed [W-1:0] fsh   [DLY][NDIR];
  logic signed [W-1:0] rhosh [DLY];
  logic signed [W-1:0] ux, uy;
  logic signed [2*W-1:0] uxx, uyy;
  logic signed [U2W-1:0] u2;

  logic signed [W-1:0] msh_rho [LL];
  logic signed [W-1:0] msh_ux  [LL];
  logic signed [W-1:0] msh_uy  [LL];
  logic signed [W-1:0] gl   [NDIR];
  logic signed [W-1:0] gout [NDIR];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign fin[0] = f_rest;
  assign fin[1] = f_east;
  assign fin[2] = f_north;
  assign fin[3] = f_west;
  assign fin[4] = f_south;
  assign fin[5] = f_northeast;
  assign fin[6] = f_northwest;
  assign fin[7] = f_southwest;
  assign fin[8] = f_southeast;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RATE_RESET;
    end else if (cfg_wr_en) begin
      relax_rate <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[VL-2:0], in_valid};
      out_valid <= vld[VL-1];
    end
  end

  // input stage: moments
  always_ff @(posedge clk) begin
    if (en) begin
      f0   <= fin;
      sum0 <= (W+4)'(fin[0]) + (W+4)'(fin[1]) + (W+4)'(fin[2]) + (W+4)'(fin[3])
            + (W+4)'(fin[4]) + (W+4)'(fin[5]) + (W+4)'(fin[6]) + (W+4)'(fin[7])
            + (W+4)'(fin[8]);
      mx0  <= (W+3)'(fin[1]) + (W+3)'(fin[5]) + (W+3)'(fin[8])
            - (W+3)'(fin[3]) - (W+3)'(fin[6]) - (W+3)'(fin[7]);
      my0  <= (W+3)'(fin[2]) + (W+3)'(fin[5]) + (W+3)'(fin[6])
            - (W+3)'(fin[4]) - (W+3)'(fin[7]) - (W+3)'(fin[8]);
    end
  end

  d2q9_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .num(mx0), .den(sum0), .quo(ux)
  );

  d2q9_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .num(my0), .den(sum0), .quo(uy)
  );

  // alignment with the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      fsh[0]   <= f0;
      rhosh[0] <= (sum0 > MAXS) ? MAXS[W-1:0] :
                  (sum0 < MINS) ? MINS[W-1:0] : sum0[W-1:0];
      for (int k = 1; k < DLY; k++) begin
        fsh[k]   <= fsh[k-1];
        rhosh[k] <= rhosh[k-1];
      end
    end
  end

  // shared speed squared, ready for lane stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      uxx <= ux * ux;
      uyy <= uy * uy;
      u2  <= U2W'(((2*W+1)'(uxx) + HALF) >>> FRAC_BITS)
           + U2W'(((2*W+1)'(uyy) + HALF) >>> FRAC_BITS);
    end
  end

  for (genvar q = 0; q < NDIR; q++) begin : g_lane
    d2q9_lane #(
      .DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CX(DIR_X[q]), .CY(DIR_Y[q])
    ) u_lane (
      .clk(clk), .en(en), .f(fsh[DLY-1][q]), .rho(rhosh[DLY-1]),
      .ux(ux), .uy(uy), .u2(u2), .omega(relax_rate), .g(gl[q])
    );
  end

  // merge: lane results with the cell moments
  always_ff @(posedge clk) begin
    if (en) begin
      msh_rho[0] <= rhosh[DLY-1];
      msh_ux[0]  <= ux;
      msh_uy[0]  <= uy;
      for (int k = 1; k < LL; k++) begin
        msh_rho[k] <= msh_rho[k-1];
        msh_ux[k]  <= msh_ux[k-1];
        msh_uy[k]  <= msh_uy[k-1];
      end
      gout    <= gl;
      density <= msh_rho[LL-1];
      vel_x   <= msh_ux[LL-1];
      vel_y   <= msh_uy[LL-1];
    end
  end

  assign g_rest      = gout[0];
  assign g_east      = gout[1];
  assign g_north     = gout[2];
  assign g_west      = gout[3];
  assign g_south     = gout[4];
  assign g_northeast = gout[5];
  assign g_northwest = gout[6];
  assign g_southwest = gout[7];
  assign g_southeast = gout[8];

  a_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (density <= 0) |-> (vel_x == 0) && (vel_y == 0))
    else $error("velocity not zero for non-positive density");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while output stalled");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
